// File: hw/rtl/mwlfo_pkg.sv
package mwlfo_pkg;

    localparam int LevelW = 24;
    localparam int Frac = 21;
    localparam int IncW = 20;
    localparam int SeedW = 32;
    localparam int LenW = 5;
    localparam int MaxLen = 24;
    localparam int CfgIdxW = 1;

    localparam logic [CfgIdxW-1:0] CfgTriIncrement = 1'd0;
    localparam logic [CfgIdxW-1:0] CfgNoiseSeed = 1'd1;

    localparam logic signed [LevelW-1:0] LvOne = 24'sd2097152;
    localparam logic signed [LevelW-1:0] LvMinusOne = -24'sd2097152;
    localparam logic signed [LevelW-1:0] LvMax = 24'sd8388607;
    localparam logic signed [LevelW-1:0] LvMin = -24'sd8388608;
    localparam logic [SeedW-1:0] LfsrMask = 32'hD000_0001;

    typedef logic signed [LevelW-1:0] t_level;

    // Per-voice state record as held in the state memory.
    typedef struct packed {
        logic        trigger_seen;
        t_level      phase;
        logic [1:0]  segment;
        t_level      slope;
        t_level      rect_level;
        t_level      saw_level;
        t_level      hold_level;
        t_level      smooth_sine;
        t_level      smooth_saw;
        t_level      smooth_hold;
        t_level      smooth_triangle;
        t_level      smooth_rect;
    } t_voice_state;

    localparam int StateW = $bits(t_voice_state);

    // The five interpolated waves of one sample.
    typedef struct packed {
        t_level sine;
        t_level triangle;
        t_level saw;
        t_level rect;
        t_level hold;
    } t_waves;

    function automatic t_level sat_level(input logic signed [LevelW+1:0] x);
        if (x > 26'(LvMax)) begin
            return LvMax;
        end else if (x < 26'(LvMin)) begin
            return LvMin;
        end
        return x[LevelW-1:0];
    endfunction

endpackage

// File: hw/rtl/mwlfo_if.sv
interface mwlfo_if #(
    parameter int W = 8
) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/mwlfo_cfg_if.sv
interface mwlfo_cfg_if ();
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/mwlfo_ram.sv
module mwlfo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: hw/rtl/mwlfo_lerp.sv
// Sequential interpolation: keeps a running numerator d*i and a quotient with
// remainder, so each sample needs only adds and one compare-subtract per wave.
// The first quotient |d| / k comes from a reciprocal multiplication at start,
// and the remainder that goes with it is formed in the following cycle.
module mwlfo_lerp (
    input  logic                        i_clk,
    input  logic                        i_start,
    input  logic                        i_div,
    input  logic                        i_step,
    input  logic [mwlfo_pkg::LenW-1:0]  i_len,
    input  mwlfo_pkg::t_waves           i_from,
    input  mwlfo_pkg::t_waves           i_to,
    output mwlfo_pkg::t_waves           o_value
);
    import mwlfo_pkg::*;

    localparam int DW = LevelW + 2;
    localparam int NW = 5;
    localparam int RecipW = 30;
    localparam int RecipShift = 29;

    logic [DW-1:0]        r_q [NW];
    logic [LenW-1:0]      r_r [NW];
    logic [DW-1:0]        r_dq [NW];
    logic [LenW-1:0]      r_dr [NW];
    logic [DW-1:0]        r_mag [NW];
    logic                 r_neg [NW];
    t_level               r_base [NW];
    t_level               w_from [NW];
    t_level               w_to [NW];
    t_level               w_out [NW];
    logic [RecipW-1:0]    w_recip;

    // Rounded-up 2^29 / k for k from 1 to 24. With |d| below 2^24 the error
    // of the reciprocal never reaches the next integer, so the product shifted
    // down is exactly the floored quotient.
    function automatic logic [RecipW-1:0] recip(input logic [LenW-1:0] k);
        unique case (k)
            5'd1:    return 30'd536870912;
            5'd2:    return 30'd268435456;
            5'd3:    return 30'd178956971;
            5'd4:    return 30'd134217728;
            5'd5:    return 30'd107374183;
            5'd6:    return 30'd89478486;
            5'd7:    return 30'd76695845;
            5'd8:    return 30'd67108864;
            5'd9:    return 30'd59652324;
            5'd10:   return 30'd53687092;
            5'd11:   return 30'd48806447;
            5'd12:   return 30'd44739243;
            5'd13:   return 30'd41297763;
            5'd14:   return 30'd38347923;
            5'd15:   return 30'd35791395;
            5'd16:   return 30'd33554432;
            5'd17:   return 30'd31580642;
            5'd18:   return 30'd29826162;
            5'd19:   return 30'd28256364;
            5'd20:   return 30'd26843546;
            5'd21:   return 30'd25565282;
            5'd22:   return 30'd24403224;
            5'd23:   return 30'd23342214;
            5'd24:   return 30'd22369622;
            default: return '0;
        endcase
    endfunction

    assign w_recip = recip(i_len);

    assign w_from = '{i_from.sine, i_from.triangle, i_from.saw, i_from.rect, i_from.hold};
    assign w_to = '{i_to.sine, i_to.triangle, i_to.saw, i_to.rect, i_to.hold};
    assign o_value = '{w_out[0], w_out[1], w_out[2], w_out[3], w_out[4]};

    for (genvar g = 0; g < NW; g++) begin : g_wave
        logic signed [DW-1:0]     w_d;
        logic [DW-1:0]            w_mag;
        logic [DW+RecipW-1:0]     w_prod;
        logic [DW-1:0]            w_rem;

        assign w_d = DW'(w_to[g]) - DW'(w_from[g]);
        assign w_mag = w_d[DW-1] ? -w_d : w_d;
        assign w_prod = (DW+RecipW)'(w_mag) * (DW+RecipW)'(w_recip);
        assign w_rem = r_mag[g] - r_dq[g] * DW'(i_len);

        always_ff @(posedge i_clk) begin
            if (i_start) begin
                r_mag[g] <= w_mag;
                r_dq[g] <= DW'(w_prod >> RecipShift);
                r_neg[g] <= w_d[DW-1];
                r_base[g] <= w_from[g];
            end else if (i_div) begin
                r_dr[g] <= LenW'(w_rem);
                r_q[g] <= r_dq[g];
                r_r[g] <= LenW'(w_rem);
            end else if (i_step) begin
                if ({1'b0, r_r[g]} + {1'b0, r_dr[g]} >= {1'b0, i_len}) begin
                    r_q[g] <= r_q[g] + r_dq[g] + DW'(1);
                    r_r[g] <= r_r[g] + r_dr[g] - i_len;
                end else begin
                    r_q[g] <= r_q[g] + r_dq[g];
                    r_r[g] <= r_r[g] + r_dr[g];
                end
            end
        end
        assign w_out[g] = LevelW'(DW'(r_base[g]) + (r_neg[g] ? -r_q[g] : r_q[g]));
    end
endmodule

// File: hw/rtl/multi_wave_lfo.sv
// Multi-waveform LFO, one oscillator per voice. Each input transaction is one
// control step for one voice and yields chunk_length output transactions (at
// most 24), one per sample, each carrying six waves in signed Q3.21 and a
// last-sample flag. Voice state lives in one synchronous memory: a step reads
// the voice's record, then goes through the control update, the multiply for
// the parabolic sine, and the interpolator setup (a reciprocal multiply for
// the quotient, then its remainder). It then emits one sample per cycle while
// the output side is ready and writes the record back with the last sample;
// one step is in flight at a time. After reset a clearing pass initialises
// the record of every voice, during which no step is accepted. Steps for an
// out-of-range voice or of zero length are consumed without any output.
module multi_wave_lfo #(
    parameter int VOICES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mwlfo_cfg_if.sink i_cfg,
    mwlfo_if.sink     i_step,
    mwlfo_if.source   o_sample
);
    import mwlfo_pkg::*;

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_READ  = 8'b00000100,
        S_CTRL  = 8'b00001000,
        S_MUL   = 8'b00010000,
        S_SETUP = 8'b00100000,
        S_DIV   = 8'b01000000,
        S_EMIT  = 8'b10000000
    } t_state;

    t_state r_state;
    logic [VW-1:0] r_clr;
    logic [IncW-1:0] r_inc;
    logic [SeedW-1:0] r_lfsr;
    logic [VW-1:0] r_voice;
    logic r_high;
    logic [LenW-1:0] r_len;
    logic [LenW-1:0] r_idx;
    t_voice_state r_st;
    logic signed [LevelW+1:0] r_mul_a;
    logic signed [LevelW+1:0] r_mul_b;
    t_level r_sine;

    // Input fields: voice[3:0], trigger_high, chunk_length[4:0].
    logic [3:0] w_in_voice;
    logic w_in_high;
    logic [LenW-1:0] w_in_len;
    assign w_in_voice = i_step.data[9:6];
    assign w_in_high = i_step.data[5];
    assign w_in_len = i_step.data[4:0];

    logic w_ram_we;
    logic [VW-1:0] w_ram_waddr;
    t_voice_state w_ram_wdata;
    t_voice_state w_ram_rdata;
    t_voice_state w_clear_rec;

    always_comb begin
        w_clear_rec = '0;
        w_clear_rec.saw_level = LvMinusOne;
    end

    mwlfo_ram #(.WIDTH(StateW), .DEPTH(1 << VW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(w_ram_waddr),
        .i_wdata(w_ram_wdata),
        .i_raddr(r_voice),
        .o_rdata(w_ram_rdata)
    );

    // LFSR step.
    logic [SeedW-1:0] w_lfsr_next;
    assign w_lfsr_next = r_lfsr[0] ? ((r_lfsr >> 1) ^ LfsrMask) : (r_lfsr >> 1);
    t_level w_rand;
    assign w_rand = t_level'({2'b00, w_lfsr_next[31:10]}) - LvOne;

    // Control update, done combinationally from the record read in S_READ.
    t_voice_state w_c;
    t_voice_state n_st;
    logic signed [LevelW-1:0] w_slope;
    logic w_draw;
    logic signed [LevelW:0] w_dt0;
    assign w_dt0 = (LevelW+1)'(r_inc);

    always_comb begin
        w_c = w_ram_rdata;
        w_slope = '0;
        w_draw = 1'b0;
        if (!w_c.trigger_seen && r_high) begin
            w_c.trigger_seen = 1'b1;
            w_c.phase = '0;
            w_c.segment = 2'd0;
            w_c.slope = LevelW'(w_dt0);
            w_c.rect_level = LvMinusOne;
            w_c.saw_level = LvMinusOne;
        end
        if (w_c.trigger_seen && !r_high) begin
            w_c.trigger_seen = 1'b0;
        end
        if (w_c.phase >= LvOne) begin
            w_c.segment = 2'd1;
            w_c.slope = LevelW'(-w_dt0);
        end else if (w_c.phase <= LvMinusOne) begin
            w_c.segment = 2'd3;
            w_c.slope = LevelW'(w_dt0);
        end else if (w_c.segment == 2'd1 && w_c.phase < 0) begin
            w_c.segment = 2'd2;
            w_c.rect_level = LvOne;
            w_draw = 1'b1;
        end else if (w_c.segment == 2'd3 && w_c.phase > 0) begin
            w_c.segment = 2'd0;
            w_c.rect_level = LvMinusOne;
            w_draw = 1'b1;
            w_c.saw_level = LvMinusOne;
        end
        if (w_draw) begin
            w_c.hold_level = w_rand;
        end
        // The phase moves by the stored slope, as a trigger or a peak left it
        // in this step. The slope kept for the next step follows the segment
        // reached here, at the step size now in force.
        w_slope = (w_c.segment == 2'd1 || w_c.segment == 2'd2)
            ? LevelW'(-w_dt0) : LevelW'(w_dt0);
    end

    always_comb begin
        n_st = w_c;
        n_st.saw_level = sat_level((LevelW+2)'(w_c.saw_level)
            + (LevelW+2)'(r_inc >> 1));
        n_st.phase = sat_level((LevelW+2)'(w_c.phase) + (LevelW+2)'(w_c.slope));
        n_st.slope = w_slope;
    end

    // A seed write loads the LFSR at once; otherwise it advances on a draw.
    logic [SeedW-1:0] n_lfsr;
    always_comb begin
        n_lfsr = r_lfsr;
        if (r_state == S_CTRL && w_draw) begin
            n_lfsr = w_lfsr_next;
        end
        if (i_cfg.valid && i_cfg.index == CfgNoiseSeed) begin
            n_lfsr = (i_cfg.data == '0) ? 32'd1 : i_cfg.data;
        end
    end

    // Sine product: t * (2 -/+ t), floored to Q3.21.
    logic signed [2*LevelW+3:0] w_prod;
    logic signed [2*LevelW+3:0] w_floor;
    assign w_prod = r_mul_a * r_mul_b;
    assign w_floor = w_prod >>> Frac;

    t_waves w_from;
    t_waves w_to;
    t_waves w_val;
    logic w_lerp_start;
    logic w_lerp_div;
    logic w_lerp_step;

    assign w_from = '{r_st.smooth_sine, r_st.smooth_triangle, r_st.smooth_saw,
                      r_st.smooth_rect, r_st.smooth_hold};
    assign w_to = '{r_sine, r_st.phase, r_st.saw_level, r_st.rect_level, r_st.hold_level};

    mwlfo_lerp u_lerp (
        .i_clk  (i_clk),
        .i_start(w_lerp_start),
        .i_div  (w_lerp_div),
        .i_step (w_lerp_step),
        .i_len  (r_len),
        .i_from (w_from),
        .i_to   (w_to),
        .o_value(w_val)
    );

    logic w_out_fire;
    logic w_last;
    assign w_out_fire = (r_state == S_EMIT) && o_sample.ready;
    assign w_last = (r_idx == r_len);
    assign w_lerp_start = (r_state == S_SETUP);
    assign w_lerp_div = (r_state == S_DIV);
    assign w_lerp_step = w_out_fire;

    assign i_step.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_sample.valid = (r_state == S_EMIT);
    assign o_sample.data = {w_val.sine, w_val.triangle, w_val.saw,
                            sat_level(-(LevelW+2)'(w_val.saw)),
                            w_val.rect, w_val.hold, w_last};

    always_comb begin
        w_ram_we = 1'b0;
        w_ram_waddr = r_voice;
        w_ram_wdata = r_st;
        if (r_state == S_CLEAR) begin
            w_ram_we = 1'b1;
            w_ram_waddr = r_clr;
            w_ram_wdata = w_clear_rec;
        end else if (w_out_fire && w_last) begin
            w_ram_we = 1'b1;
            w_ram_wdata.smooth_sine = r_sine;
            w_ram_wdata.smooth_triangle = r_st.phase;
            w_ram_wdata.smooth_saw = r_st.saw_level;
            w_ram_wdata.smooth_rect = r_st.rect_level;
            w_ram_wdata.smooth_hold = r_st.hold_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_inc <= IncW'(15219);
            r_lfsr <= 32'd1;
        end else begin
            if (i_cfg.valid && i_cfg.index == CfgTriIncrement) begin
                r_inc <= i_cfg.data[IncW-1:0];
            end
            r_lfsr <= n_lfsr;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == VW'(VOICES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_step.valid && 32'(w_in_voice) < VOICES && w_in_len != '0) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_CTRL;
                S_CTRL: r_state <= S_MUL;
                S_MUL: r_state <= S_SETUP;
                S_SETUP: r_state <= S_DIV;
                S_DIV: r_state <= S_EMIT;
                S_EMIT: begin
                    if (w_out_fire && w_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_voice <= VW'(w_in_voice);
            r_high <= w_in_high;
            r_len <= (w_in_len > LenW'(MaxLen)) ? LenW'(MaxLen) : w_in_len;
            r_idx <= LenW'(1);
        end
        if (r_state == S_CTRL) begin
            r_st <= n_st;
            r_mul_a <= (LevelW+2)'(w_c.phase);
            r_mul_b <= (w_c.segment < 2'd2)
                ? (LevelW+2)'(2 * LvOne) - (LevelW+2)'(w_c.phase)
                : (LevelW+2)'(2 * LvOne) + (LevelW+2)'(w_c.phase);
        end
        if (r_state == S_MUL) begin
            if (w_floor > (2*LevelW+4)'(LvMax)) begin
                r_sine <= LvMax;
            end else if (w_floor < (2*LevelW+4)'(LvMin)) begin
                r_sine <= LvMin;
            end else begin
                r_sine <= w_floor[LevelW-1:0];
            end
        end
        if (w_out_fire) begin
            r_idx <= r_idx + 1'b1;
        end
    end

endmodule
